// ===== rtl/core/sorted_min_priority_queue_top_assert.svh =====
// Assertion macros shared by the queue modules.
`ifndef SORTED_MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only out of reset
`define SMPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included
`define SMPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMPQ_ASSERT(label, clk, rst_n, prop, msg)
`define SMPQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/smpq_pkg.sv =====
package smpq_pkg;

    // Storage geometry
    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 5;

    // Operation codes carried on the mode input
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [COUNT_BITS-1:0]        t_count;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_REPORT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic exec;
        logic report;
    } t_dp_cmd;

endpackage

// ===== rtl/core/sorted_min_priority_queue_top.sv =====
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+--------------------------------------
// command   | in        | start, busy          | i_mode, i_value
// result    | out       | o_valid (one cycle)  | o_removed_value, o_head_value,
//           |           |                      | o_entry_count, o_is_empty, o_op_error
//
// The sorted register file updates on the accept edge through one bank of parallel
// compares, and the result shows the following cycle.
// busy is high during the result cycle; start is taken again the cycle after.
// Synchronous active-low reset empties the queue; the store itself is not cleared.
// The receiver cannot stall: each result is present for exactly one cycle.
module sorted_min_priority_queue_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_mode,
    input  smpq_pkg::t_value       i_value,
    output logic                   o_valid,
    output smpq_pkg::t_value       o_removed_value,
    output smpq_pkg::t_value       o_head_value,
    output smpq_pkg::t_count       o_entry_count,
    output logic                   o_is_empty,
    output logic                   o_op_error
);

    smpq_pkg::t_dp_cmd dp_cmd;

    // Sequencer
    smpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd)
    );

    // Sorted store and result registers
    smpq_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .o_removed_value (o_removed_value),
        .o_head_value    (o_head_value),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_op_error      (o_op_error)
    );

endmodule

// ===== rtl/core/smpq_datapath.sv =====
`include "sorted_min_priority_queue_top_assert.svh"

module smpq_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smpq_pkg::t_dp_cmd     i_cmd,
    input  logic                  i_mode,
    input  smpq_pkg::t_value      i_value,
    output smpq_pkg::t_value      o_removed_value,
    output smpq_pkg::t_value      o_head_value,
    output smpq_pkg::t_count      o_entry_count,
    output logic                  o_is_empty,
    output logic                  o_op_error
);

    smpq_pkg::t_value r_entries [smpq_pkg::CAPACITY];
    smpq_pkg::t_value n_entries [smpq_pkg::CAPACITY];
    smpq_pkg::t_count r_count;
    smpq_pkg::t_count n_count;
    smpq_pkg::t_value r_removed;
    smpq_pkg::t_value n_removed;
    logic             r_err;
    logic             n_err;

    logic [smpq_pkg::CAPACITY-1:0] at_or_past;
    logic                          full;
    logic                          empty;

    assign full  = (r_count == smpq_pkg::t_count'(smpq_pkg::CAPACITY));
    assign empty = (r_count == '0);

    // Per-entry compare: entry lies at or beyond the insert slot
    always_comb begin
        for (int i = 0; i < smpq_pkg::CAPACITY; i++) begin
            at_or_past[i] = (i_value < r_entries[i]) ||
                            (smpq_pkg::t_count'(i) >= r_count);
        end
    end

    // Next store contents: shift up on insert, shift down on remove
    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        n_removed = r_removed;
        n_err     = r_err;
        if (i_cmd.exec) begin
            n_removed = '0;
            n_err     = 1'b0;
            if (i_mode == smpq_pkg::MODE_INSERT) begin
                if (full) begin
                    n_err = 1'b1;
                end else begin
                    for (int i = 0; i < smpq_pkg::CAPACITY; i++) begin
                        if (at_or_past[i]) begin
                            if (i > 0 && at_or_past[(i > 0) ? i - 1 : 0]) begin
                                n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                            end else begin
                                n_entries[i] = i_value;
                            end
                        end
                    end
                    n_count = r_count + smpq_pkg::t_count'(1);
                end
            end else begin
                if (empty) begin
                    n_err = 1'b1;
                end else begin
                    n_removed = r_entries[0];
                    for (int i = 0; i < smpq_pkg::CAPACITY - 1; i++) begin
                        n_entries[i] = r_entries[i+1];
                    end
                    n_count = r_count - smpq_pkg::t_count'(1);
                end
            end
        end
    end

    // Store and result registers
    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
        r_removed <= n_removed;
        r_err     <= n_err;
    end

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_removed_value = i_cmd.report ? r_removed : '0;
    assign o_head_value    = empty ? '0 : r_entries[0];
    assign o_entry_count   = r_count;
    assign o_is_empty      = empty;
    assign o_op_error      = r_err;

    `SMPQ_ASSERT(a_count_bound, i_clk, i_rst_n,
        r_count <= smpq_pkg::t_count'(smpq_pkg::CAPACITY), "occupancy beyond capacity")
    `SMPQ_ASSERT(a_insert_grows, i_clk, i_rst_n,
        (i_cmd.exec && i_mode == smpq_pkg::MODE_INSERT && !full) |=> (r_count == $past(r_count) + smpq_pkg::t_count'(1)), "insert did not grow queue")
    `SMPQ_ASSERT(a_head_sorted, i_clk, i_rst_n,
        (r_count >= smpq_pkg::t_count'(2)) |-> (r_entries[0] <= r_entries[1]), "head entries out of order")

endmodule

// ===== rtl/core/smpq_ctrl.sv =====
`include "sorted_min_priority_queue_top_assert.svh"

module smpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    output logic               o_valid,
    output smpq_pkg::t_dp_cmd  o_cmd
);

    smpq_pkg::t_state r_state;
    smpq_pkg::t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            smpq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = smpq_pkg::S_REPORT;
                end
            end
            smpq_pkg::S_REPORT: begin
                n_state = smpq_pkg::S_IDLE;
            end
            default: begin
                n_state = smpq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_busy       = 1'b0;
        o_valid      = 1'b0;
        o_cmd.exec   = 1'b0;
        o_cmd.report = 1'b0;
        case (r_state)
            smpq_pkg::S_IDLE: begin
                o_cmd.exec = i_start;
            end
            smpq_pkg::S_REPORT: begin
                o_busy       = 1'b1;
                o_valid      = 1'b1;
                o_cmd.report = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SMPQ_ASSERT(a_exec_reports, i_clk, i_rst_n,
        o_cmd.exec |=> o_valid, "accepted item gave no result")
    `SMPQ_ASSERT(a_single_strobe, i_clk, i_rst_n,
        o_valid |=> !o_valid, "result strobe longer than one cycle")
    `SMPQ_ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> (!o_valid && !o_busy), "not idle after reset")

endmodule

// ===== tb/tb_sorted_min_priority_queue_top.sv =====
module tb_sorted_min_priority_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any handshake before the run is declared hung
    localparam int NO_PROGRESS_LIMIT = 1000;
    // Quiet cycles after the last result, to catch stray strobes
    localparam int TAIL_CYCLES       = 8;
    // Mismatch lines printed before going quiet (all are still counted)
    localparam int MAX_PRINTED       = 40;
    // Slots in the ring of owed results; at most one is ever pending
    localparam int EXPECT_DEPTH      = 4;

    // One result item
    typedef struct packed {
        smpq_pkg::t_value removed;
        smpq_pkg::t_value head;
        smpq_pkg::t_count count;
        logic             empty;
        logic             op_error;
    } t_queue_report;

    // One row of the directed table; known rows carry a hand-written result
    typedef struct packed {
        logic             mode;
        smpq_pkg::t_value value;
        logic             known;
        t_queue_report    want;
    } t_stim_row;

    localparam t_queue_report PREDICTED = '0;
    localparam int NUM_DIRECTED = 22;

    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // remove on empty is refused
        '{smpq_pkg::MODE_REMOVE, 32'h0000_0000, 1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, 1'b1}},
        // largest and smallest values
        '{smpq_pkg::MODE_INSERT, 32'h7FFF_FFFF, 1'b1,
          '{32'h0, 32'h7FFF_FFFF, 5'd1, 1'b0, 1'b0}},
        '{smpq_pkg::MODE_INSERT, 32'h8000_0000, 1'b1,
          '{32'h0, 32'h8000_0000, 5'd2, 1'b0, 1'b0}},
        // value ignored on remove
        '{smpq_pkg::MODE_REMOVE, 32'h5A5A_5A5A, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 5'd1, 1'b0, 1'b0}},
        // around zero, with ties
        '{smpq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'h0000_0000, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'h0000_0000, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'h0000_0001, 1'b0, PREDICTED},
        // fill up to capacity
        '{smpq_pkg::MODE_INSERT, 32'h8000_0000, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'hFFFF_FFFE, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'h0000_0002, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'h4000_0000, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'hC000_0000, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'h0000_0001, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'h7FFF_FFFE, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'h8000_0001, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'h5555_5555, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'hAAAA_AAAA, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_INSERT, 32'h7FFF_FFFF, 1'b0, PREDICTED},
        // insert on full is refused, value dropped
        '{smpq_pkg::MODE_INSERT, 32'h1234_5678, 1'b1,
          '{32'h0, 32'h8000_0000, 5'd16, 1'b0, 1'b1}},
        '{smpq_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 1'b0, PREDICTED},
        '{smpq_pkg::MODE_REMOVE, 32'h0000_0000, 1'b0, PREDICTED}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_mode;
    smpq_pkg::t_value i_value;
    logic             o_valid;
    smpq_pkg::t_value o_removed_value;
    smpq_pkg::t_value o_head_value;
    smpq_pkg::t_count o_entry_count;
    logic             o_is_empty;
    logic             o_op_error;

    sorted_min_priority_queue_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .o_removed_value (o_removed_value),
        .o_head_value    (o_head_value),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_op_error      (o_op_error)
    );

    // Mirror of the queue contents and the results still owed by the block
    smpq_pkg::t_value mirror_entries [smpq_pkg::CAPACITY];
    int unsigned      mirror_fill;
    t_queue_report    expected_reports [EXPECT_DEPTH];
    int unsigned      expect_wr;
    int unsigned      expect_rd;

    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned mismatch_count;
    int unsigned inserts_done;
    int unsigned removes_done;
    int unsigned refused_inserts;
    int unsigned refused_removes;
    int unsigned stalled_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one operation to the mirror and return the result it should give
    function automatic t_queue_report apply_queue_op(input logic mode,
                                                     input smpq_pkg::t_value value);
        t_queue_report rep;
        int unsigned   pos;
        int unsigned   i;
        rep = '0;
        if (mode == smpq_pkg::MODE_INSERT) begin
            if (mirror_fill >= smpq_pkg::CAPACITY) begin
                rep.op_error = 1'b1;
                refused_inserts++;
            end else begin
                // equal values go behind the ones already stored
                pos = 0;
                while (pos < mirror_fill && !(value < mirror_entries[pos]))
                    pos++;
                for (i = mirror_fill; i > pos; i--)
                    mirror_entries[i] = mirror_entries[i-1];
                mirror_entries[pos] = value;
                mirror_fill++;
                inserts_done++;
            end
        end else begin
            if (mirror_fill == 0) begin
                rep.op_error = 1'b1;
                refused_removes++;
            end else begin
                rep.removed = mirror_entries[0];
                for (i = 1; i < mirror_fill; i++)
                    mirror_entries[i-1] = mirror_entries[i];
                mirror_fill--;
                removes_done++;
            end
        end
        rep.head  = (mirror_fill > 0) ? mirror_entries[0] : smpq_pkg::t_value'(0);
        rep.count = smpq_pkg::t_count'(mirror_fill);
        rep.empty = (mirror_fill == 0);
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] result %0d: %s expected %h got %h",
                     $realtime, results_checked, what, want, got);
    endtask

    // Mostly uniform values, some ties around zero, some extremes
    function automatic smpq_pkg::t_value pick_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            1, 2: return smpq_pkg::t_value'($urandom_range(8)) - smpq_pkg::t_value'(4);
            default: return smpq_pkg::t_value'($urandom);
        endcase
    endfunction

    // Sender gap: start low for a random number of cycles, junk on the payload
    task automatic idle_gap(input int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start   <= 1'b0;
            i_mode  <= 1'($urandom);
            i_value <= smpq_pkg::t_value'($urandom);
            @(posedge i_clk);
        end
    endtask

    // Present one item and hold it until the block takes it
    task automatic send_item(input logic mode, input smpq_pkg::t_value value,
                             input logic known, input t_queue_report want);
        t_queue_report rep;
        start   <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        rep = apply_queue_op(mode, value);
        expected_reports[expect_wr % EXPECT_DEPTH] = known ? want : rep;
        expect_wr++;
        items_sent++;
    endtask

    // Hold off until every owed result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (expect_wr != expect_rd)
            @(posedge i_clk);
    endtask

    // Random traffic in bursts that lean toward filling, emptying or neither
    task automatic run_phase(input int unsigned n_items, input int unsigned idle_pct);
        int unsigned insert_pct;
        int unsigned burst_left;
        logic        mode;
        insert_pct = 50;
        burst_left = 0;
        repeat (n_items) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(40, 8);
                case ($urandom_range(3))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 55;
                endcase
            end
            burst_left--;
            mode = ($urandom_range(99) < insert_pct) ? smpq_pkg::MODE_INSERT
                                                     : smpq_pkg::MODE_REMOVE;
            idle_gap(idle_pct);
            send_item(mode, pick_value(), 1'b0, PREDICTED);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_queue_report want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expect_wr == expect_rd) begin
                report_mismatch("result with no item pending", 32'h0, 32'h1);
            end else begin
                want = expected_reports[expect_rd % EXPECT_DEPTH];
                expect_rd++;
                if (o_removed_value !== want.removed)
                    report_mismatch("removed_value", want.removed, o_removed_value);
                if (o_head_value !== want.head)
                    report_mismatch("head_value", want.head, o_head_value);
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", 32'(want.count), 32'(o_entry_count));
                if (o_is_empty !== want.empty)
                    report_mismatch("is_empty", 32'(want.empty), 32'(o_is_empty));
                if (o_op_error !== want.op_error)
                    report_mismatch("op_error", 32'(want.op_error), 32'(o_op_error));
            end
            results_checked++;
        end
    end

    // Watchdog: no item taken and no result for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= NO_PROGRESS_LIMIT) begin
            $display("[%0t] no progress for %0d cycles, %0d results outstanding",
                     $realtime, stalled_cycles, expect_wr - expect_rd);
            $display("== FAIL ==");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        items_sent      = 0;
        results_checked = 0;
        mismatch_count  = 0;
        inserts_done    = 0;
        removes_done    = 0;
        refused_inserts = 0;
        refused_removes = 0;
        stalled_cycles  = 0;
        mirror_fill     = 0;
        expect_wr       = 0;
        expect_rd       = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_mode  <= smpq_pkg::MODE_INSERT;
        i_value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (DIRECTED_ROWS[r]) begin
            idle_gap(36);
            send_item(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].value,
                      DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].want);
        end
        drain_results();

        // Random traffic: sender busy-ish, then sparse, then flat out
        run_phase(1950 / 3 - NUM_DIRECTED, 36);
        drain_results();
        run_phase(1950 / 3, 66);
        drain_results();
        run_phase(1950 - 2 * (1950 / 3), 0);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d inserts, %0d removes, %0d refused on full, %0d on empty",
                 items_sent, inserts_done, removes_done, refused_inserts, refused_removes);
        $display("Checked %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
